// ----- rtl/mukio_pkg.sv -----
// shared types, register codes and bit masks for the midi uart and keyboard latch block
// depends on nothing; imported by every module of the block except mukio_ram
package mukio_pkg;

    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_RX    = 2'd3;

    localparam logic [2:0] OFF_KEYBOARD = 3'd2;
    localparam logic [2:0] OFF_VECTOR   = 3'd3;
    localparam logic [2:0] OFF_DATA     = 3'd5;
    localparam logic [2:0] OFF_STATUS   = 3'd6;

    localparam logic [7:0] ST_TXEMPTY = 8'h01;
    localparam logic [7:0] ST_RXRDY   = 8'h02;
    localparam logic [7:0] ST_OE      = 8'h20;
    localparam logic [7:0] MD_TXINT   = 8'h10;
    localparam logic [7:0] MD_RXINT   = 8'h20;
    localparam logic [7:0] MD_RESET   = 8'h80;

    localparam logic [7:0]  UNMAPPED_READ   = 8'hFF;
    localparam logic [15:0] CHAR_TIME_RESET = 16'd144;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic need_load;
        logic out_free;
    } t_dp_sts;

    function automatic logic [7:0] col_mask(input int col);
        logic [7:0] m;
        case (col)
            0: m = 8'h01;
            1: m = 8'h02;
            2: m = 8'h04;
            3: m = 8'h10;
            4: m = 8'h20;
            5: m = 8'h40;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] keyboard_scan(input logic [7:0] rows,
                                                 input logic [47:0] keys);
        logic [7:0] val;
        val = 8'hFF;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 6; c++) begin
                if (rows[r] && keys[r*6 + c]) begin
                    val = val & ~col_mask(c);
                end
            end
        end
        return val;
    endfunction

endpackage

// ----- rtl/mukio_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
module mukio_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/mukio_ctrl.sv -----
// sequencing state machine: accept, execute, optional ring load, result push
// depends on mukio_pkg
module mukio_ctrl
    import mukio_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_dp_sts i_sts,
    output logic    o_stall,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.need_load ? S_LOAD : S_PUSH;
            end
            S_LOAD: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
            end
            S_PUSH: begin
                o_cmd.push = i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/mukio_dp.sv -----
// datapath: uart registers, character timers, receive ring and output word register
// depends on mukio_pkg and mukio_ram
module mukio_dp
    import mukio_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,
    input  logic [1:0]    i_command,
    input  logic [2:0]    i_reg_offset,
    input  logic [7:0]    i_write_data,
    input  logic [7:0]    i_rx_byte,
    input  logic [47:0]   i_key_pressed,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output logic [7:0]    o_read_data,
    output logic          o_irq,
    output logic [7:0]    o_int_vector,
    output logic          o_tx_valid,
    output logic [7:0]    o_tx_byte,
    output logic          o_rx_dropped
);

    // captured item
    logic [1:0]  r_command;
    logic [2:0]  r_offset;
    logic [7:0]  r_wdata;
    logic [7:0]  r_rx_byte;
    logic [47:0] r_keys;

    // block state
    logic [RING_AW-1:0] r_head, n_head;
    logic [RING_AW-1:0] r_count, n_count;
    logic [7:0]  r_holding, n_holding;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_mode, n_mode;
    logic [7:0]  r_vector, n_vector;
    logic [7:0]  r_row, n_row;
    logic [15:0] r_recv_cnt, n_recv_cnt;
    logic [15:0] r_tx_cnt, n_tx_cnt;
    logic        r_irq, n_irq;
    logic [15:0] r_char_time;

    // pending result
    logic [7:0]  r_res_rd, n_res_rd;
    logic        r_res_txv, n_res_txv;
    logic [7:0]  r_res_txb, n_res_txb;
    logic        r_res_drop, n_res_drop;

    // output word register
    logic        r_out_valid;
    logic [7:0]  r_out_rd;
    logic        r_out_irq;
    logic [7:0]  r_out_vector;
    logic        r_out_txv;
    logic [7:0]  r_out_txb;
    logic        r_out_drop;

    logic [15:0]        period;
    logic               need_load;
    logic               ram_we;
    logic               ram_re;
    logic [RING_AW-1:0] ram_rd_addr;
    logic [7:0]         ram_rd_data;

    assign period      = (r_char_time == 16'd0) ? 16'd1 : r_char_time;
    assign ram_rd_addr = r_head - r_count;

    mukio_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_head),
        .i_wr_data (r_rx_byte),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_holding  = r_holding;
        n_status   = r_status;
        n_mode     = r_mode;
        n_vector   = r_vector;
        n_row      = r_row;
        n_recv_cnt = r_recv_cnt;
        n_tx_cnt   = r_tx_cnt;
        n_irq      = r_irq;
        n_res_rd   = r_res_rd;
        n_res_txv  = r_res_txv;
        n_res_txb  = r_res_txb;
        n_res_drop = r_res_drop;
        need_load  = 1'b0;
        ram_we     = 1'b0;
        if (i_cmd.exec) begin
            n_res_rd   = 8'h00;
            n_res_txv  = 1'b0;
            n_res_txb  = 8'h00;
            n_res_drop = 1'b0;
            case (r_command)
                CMD_TICK: begin
                    if (r_recv_cnt <= 16'd1) begin
                        if ((r_status & ST_RXRDY) != 8'h00) begin
                            n_status = r_status | ST_OE;
                        end else if (r_count != '0) begin
                            need_load = 1'b1;
                            n_count   = r_count - 1'b1;
                            n_status  = r_status | ST_RXRDY;
                            if ((r_mode & MD_RXINT) != 8'h00) begin
                                n_irq = 1'b1;
                            end
                        end
                        n_recv_cnt = period;
                    end else begin
                        n_recv_cnt = r_recv_cnt - 16'd1;
                    end
                    if (r_tx_cnt != 16'd0) begin
                        n_tx_cnt = r_tx_cnt - 16'd1;
                        if (r_tx_cnt == 16'd1) begin
                            n_status = n_status | ST_TXEMPTY;
                            if ((r_mode & MD_TXINT) != 8'h00) begin
                                n_irq = 1'b1;
                            end
                        end
                    end
                end
                CMD_READ: begin
                    case (r_offset)
                        OFF_KEYBOARD: begin
                            n_res_rd = keyboard_scan(r_row, r_keys);
                        end
                        OFF_DATA: begin
                            n_res_rd = r_holding;
                            n_status = r_status & ~(ST_RXRDY | ST_OE);
                        end
                        OFF_STATUS: begin
                            n_res_rd = r_status;
                            n_irq    = 1'b0;
                        end
                        default: begin
                            n_res_rd = UNMAPPED_READ;
                        end
                    endcase
                end
                CMD_WRITE: begin
                    case (r_offset)
                        OFF_KEYBOARD: begin
                            n_row = r_wdata;
                        end
                        OFF_VECTOR: begin
                            n_vector = r_wdata;
                        end
                        OFF_DATA: begin
                            if ((r_status & ST_TXEMPTY) != 8'h00) begin
                                n_res_txv = 1'b1;
                                n_res_txb = r_wdata;
                                n_tx_cnt  = period;
                            end
                        end
                        OFF_STATUS: begin
                            n_mode = r_wdata;
                            if ((r_wdata & MD_RESET) != 8'h00) begin
                                n_status = ST_TXEMPTY;
                                n_count  = '0;
                                n_tx_cnt = 16'd0;
                                n_mode   = 8'h00;
                            end
                            n_recv_cnt = period;
                        end
                        default: begin
                            n_mode = r_mode;
                        end
                    endcase
                end
                CMD_RX: begin
                    if (r_count != {RING_AW{1'b1}}) begin
                        ram_we  = 1'b1;
                        n_head  = r_head + 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_res_drop = 1'b1;
                    end
                end
                default: begin
                    n_res_drop = 1'b0;
                end
            endcase
        end
        if (i_cmd.load) begin
            n_holding = ram_rd_data;
        end
    end

    assign ram_re = need_load;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_command;
            r_offset  <= i_reg_offset;
            r_wdata   <= i_write_data;
            r_rx_byte <= i_rx_byte;
            r_keys    <= i_key_pressed;
        end
        r_res_rd   <= n_res_rd;
        r_res_txv  <= n_res_txv;
        r_res_txb  <= n_res_txb;
        r_res_drop <= n_res_drop;
        if (i_cmd.push) begin
            r_out_rd     <= r_res_rd;
            r_out_irq    <= r_irq;
            r_out_vector <= r_vector;
            r_out_txv    <= r_res_txv;
            r_out_txb    <= r_res_txb;
            r_out_drop   <= r_res_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_holding   <= 8'h00;
            r_status    <= ST_TXEMPTY;
            r_mode      <= 8'h00;
            r_vector    <= 8'h00;
            r_row       <= 8'h00;
            r_recv_cnt  <= CHAR_TIME_RESET;
            r_tx_cnt    <= 16'd0;
            r_irq       <= 1'b0;
            r_char_time <= CHAR_TIME_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_holding  <= n_holding;
            r_status   <= n_status;
            r_mode     <= n_mode;
            r_vector   <= n_vector;
            r_row      <= n_row;
            r_recv_cnt <= n_recv_cnt;
            r_tx_cnt   <= n_tx_cnt;
            r_irq      <= n_irq;
            if (i_cfg_wr_en) begin
                r_char_time <= i_cfg_wr_data;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.need_load = need_load;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_out_rd;
    assign o_irq        = r_out_irq;
    assign o_int_vector = r_out_vector;
    assign o_tx_valid   = r_out_txv;
    assign o_tx_byte    = r_out_txb;
    assign o_rx_dropped = r_out_drop;

endmodule

// ----- rtl/midi_uart_keyboard_io.sv -----
// top level of the midi uart and keyboard latch block: controller plus datapath
// depends on mukio_pkg, mukio_ctrl, mukio_dp (which holds the ring ram)
//
//   channel   direction  handshake            payload
//   item      in         i_valid / o_stall    i_command i_reg_offset i_write_data
//                                             i_rx_byte i_key_pressed
//   result    out        o_valid / i_stall    o_read_data o_irq o_int_vector
//                                             o_tx_valid o_tx_byte o_rx_dropped
//   config    in         i_cfg_wr_en          i_cfg_wr_data (char_time)
//
// one word at a time: accept, execute, push; a tick that moves
// a ring byte into the data register adds a ring load step for the registered ring read
// a stalled result holds the push step until the output register frees up
// synchronous active-low reset; the ring ram has no reset and needs no clearing pass
module midi_uart_keyboard_io
    import mukio_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_reg_offset,
    input  logic [7:0]  i_write_data,
    input  logic [7:0]  i_rx_byte,
    input  logic [47:0] i_key_pressed,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_irq,
    output logic [7:0]  o_int_vector,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_rx_dropped
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mukio_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (dp_sts),
        .o_stall (o_stall),
        .o_cmd   (dp_cmd)
    );

    mukio_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_command     (i_command),
        .i_reg_offset  (i_reg_offset),
        .i_write_data  (i_write_data),
        .i_rx_byte     (i_rx_byte),
        .i_key_pressed (i_key_pressed),
        .i_out_stall   (i_stall),
        .o_out_valid   (o_valid),
        .o_read_data   (o_read_data),
        .o_irq         (o_irq),
        .o_int_vector  (o_int_vector),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_rx_dropped  (o_rx_dropped)
    );

    // a word in flight blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("item accepted while previous one in flight");

    // no result word is pushed during execute or ring load
    a_push_only_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.push |-> (!dp_cmd.exec && !dp_cmd.load && dp_sts.out_free)))
        else $error("result push outside push step");

    // a word cannot both send and drop
    a_send_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_tx_valid && o_rx_dropped))
        else $error("tx and drop in one word");

    // tx byte is zero when nothing is sent
    a_tx_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tx_valid) |-> (o_tx_byte == 8'h00))
        else $error("tx byte set without tx valid");

endmodule

// ----- dv/midi_uart_keyboard_io_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for midi_uart_keyboard_io: directed table, then random phases
// depends on mukio_pkg and the rtl of the block; keeps its own copy of ring, timers and flags
module midi_uart_keyboard_io_tb;
    import mukio_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MIX_NORMAL  = 0;
    localparam int MIX_FLOOD   = 1;
    localparam int MIX_DRAIN   = 2;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  reg_offset;
        logic [7:0]  write_data;
        logic [7:0]  rx_byte;
        logic [47:0] key_pressed;
    } t_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] int_vector;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
    } t_reply;

    typedef struct packed {
        t_word       w;
        logic        cfg_wr;
        logic [15:0] cfg_val;
        logic        typed;
        logic [7:0]  typed_rd;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = '0;
    logic [2:0]  i_reg_offset = '0;
    logic [7:0]  i_write_data = '0;
    logic [7:0]  i_rx_byte = '0;
    logic [47:0] i_key_pressed = '0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_irq;
    logic [7:0]  o_int_vector;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_rx_dropped;

    midi_uart_keyboard_io uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_reg_offset  (i_reg_offset),
        .i_write_data  (i_write_data),
        .i_rx_byte     (i_rx_byte),
        .i_key_pressed (i_key_pressed),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data),
        .o_irq         (o_irq),
        .o_int_vector  (o_int_vector),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_rx_dropped  (o_rx_dropped)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted block state
    logic [7:0]  rx_store [RING_DEPTH];
    int unsigned store_head;
    int unsigned store_count;
    int unsigned recv_left;
    int unsigned tx_left;
    logic [7:0]  data_hold;
    logic [7:0]  status_q;
    logic [7:0]  mode_q;
    logic [7:0]  vector_q;
    logic [7:0]  rows_q;
    logic        irq_q;
    logic [15:0] char_time_q;

    t_reply io_replies[$];
    t_reply want_reply;
    int     fail_count = 0;
    int     words_sent = 0;
    int     replies_checked = 0;
    int     drops_seen = 0;
    int     tx_seen = 0;
    int     irq_seen = 0;
    int     cycle_count = 0;
    bit     sender_idle_on = 1'b0;
    bit     rcv_idle_on = 1'b0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;
    int     stall_left = 0;

    function automatic t_reply apply_io_word(input t_word w);
        t_reply      r;
        int unsigned per;
        logic [7:0]  kb;
        int          rr;
        int          c;
        r = '0;
        per = (char_time_q == 16'd0) ? 1 : 32'(char_time_q);
        case (w.command)
            CMD_TICK: begin
                if (recv_left <= 1) begin
                    if ((status_q & ST_RXRDY) != 0) begin
                        status_q = status_q | ST_OE;
                    end else if (store_count != 0) begin
                        data_hold = rx_store[RING_AW'((store_head + RING_DEPTH - store_count)
                                                      % RING_DEPTH)];
                        store_count--;
                        status_q = status_q | ST_RXRDY;
                        if ((mode_q & MD_RXINT) != 0) irq_q = 1'b1;
                    end
                    recv_left = per;
                end else begin
                    recv_left--;
                end
                if (tx_left != 0) begin
                    tx_left--;
                    if (tx_left == 0) begin
                        status_q = status_q | ST_TXEMPTY;
                        if ((mode_q & MD_TXINT) != 0) irq_q = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                case (w.reg_offset)
                    OFF_KEYBOARD: begin
                        kb = 8'hFF;
                        for (rr = 0; rr < 8; rr++) begin
                            for (c = 0; c < 6; c++) begin
                                if (rows_q[rr] && w.key_pressed[rr*6 + c]) begin
                                    kb[3'((c < 3) ? c : c + 1)] = 1'b0;
                                end
                            end
                        end
                        r.read_data = kb;
                    end
                    OFF_DATA: begin
                        r.read_data = data_hold;
                        status_q = status_q & ~(ST_RXRDY | ST_OE);
                    end
                    OFF_STATUS: begin
                        r.read_data = status_q;
                        irq_q = 1'b0;
                    end
                    default: r.read_data = UNMAPPED_READ;
                endcase
            end
            CMD_WRITE: begin
                case (w.reg_offset)
                    OFF_KEYBOARD: rows_q = w.write_data;
                    OFF_VECTOR: vector_q = w.write_data;
                    OFF_DATA: begin
                        if ((status_q & ST_TXEMPTY) != 0) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = w.write_data;
                            tx_left = per;
                        end
                    end
                    OFF_STATUS: begin
                        mode_q = w.write_data;
                        if ((w.write_data & MD_RESET) != 0) begin
                            status_q = ST_TXEMPTY;
                            store_count = 0;
                            tx_left = 0;
                            mode_q = '0;
                        end
                        recv_left = per;
                    end
                    default: ;
                endcase
            end
            default: begin
                if (store_count < RING_DEPTH - 1) begin
                    rx_store[RING_AW'(store_head)] = w.rx_byte;
                    store_head = (store_head + 1) % RING_DEPTH;
                    store_count++;
                end else begin
                    r.rx_dropped = 1'b1;
                end
            end
        endcase
        r.irq = irq_q;
        r.int_vector = vector_q;
        return r;
    endfunction

    function automatic t_word rand_word(input int mix);
        t_word       w;
        logic [63:0] k;
        int          p;
        k = {$urandom(), $urandom()};
        w.key_pressed = k[47:0];
        w.write_data = 8'($urandom_range(255));
        w.rx_byte = 8'($urandom_range(255));
        w.reg_offset = 3'($urandom_range(7));
        p = $urandom_range(99);
        if (mix == MIX_FLOOD) begin
            if (p < 94) begin
                w.command = CMD_RX;
            end else if (p < 97) begin
                w.command = CMD_TICK;
            end else begin
                w.command = CMD_READ;
                w.reg_offset = OFF_STATUS;
            end
        end else if (mix == MIX_DRAIN) begin
            if (p < 50) begin
                w.command = CMD_TICK;
            end else begin
                w.command = CMD_READ;
                w.reg_offset = (p < 80) ? OFF_DATA : OFF_STATUS;
            end
        end else if (p < 35) begin
            w.command = CMD_TICK;
        end else if (p < 55) begin
            w.command = CMD_RX;
        end else if (p < 80) begin
            w.command = CMD_READ;
            case ($urandom_range(3))
                0: w.reg_offset = OFF_KEYBOARD;
                1: w.reg_offset = OFF_DATA;
                2: w.reg_offset = OFF_STATUS;
                default: ;
            endcase
        end else begin
            w.command = CMD_WRITE;
            case ($urandom_range(4))
                0: w.reg_offset = OFF_KEYBOARD;
                1: w.reg_offset = OFF_DATA;
                2: begin
                    w.reg_offset = OFF_STATUS;
                    if ($urandom_range(3) != 0) w.write_data[7] = 1'b0;
                end
                3: w.reg_offset = OFF_VECTOR;
                default: ;
            endcase
        end
        return w;
    endfunction

    function automatic t_row mk_row(input logic [1:0] cmd, input logic [2:0] off,
                                    input logic [7:0] wd, input logic [7:0] rb,
                                    input logic [47:0] keys, input logic typed,
                                    input logic [7:0] typed_rd);
        t_row r;
        r = '0;
        r.w.command = cmd;
        r.w.reg_offset = off;
        r.w.write_data = wd;
        r.w.rx_byte = rb;
        r.w.key_pressed = keys;
        r.typed = typed;
        r.typed_rd = typed_rd;
        return r;
    endfunction

    task automatic send_word(input t_word w, input logic typed, input logic [7:0] typed_rd);
        t_reply r;
        i_valid <= 1'b1;
        i_command <= w.command;
        i_reg_offset <= w.reg_offset;
        i_write_data <= w.write_data;
        i_rx_byte <= w.rx_byte;
        i_key_pressed <= w.key_pressed;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        r = apply_io_word(w);
        if (typed) r.read_data = typed_rd;
        io_replies.push_back(r);
        words_sent++;
        if (sender_idle_on && $urandom_range(4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (io_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_char_time(input logic [15:0] v);
        wait_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        char_time_q = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // receiver: random stall bursts plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (rcv_idle_on && $urandom_range(7) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (io_replies.size() == 0) begin
                $error("reply word with nothing pending");
                fail_count++;
            end else begin
                want_reply = io_replies.pop_front();
                check_field("read_data", want_reply.read_data, o_read_data);
                check_field("irq", 8'(want_reply.irq), 8'(o_irq));
                check_field("int_vector", want_reply.int_vector, o_int_vector);
                check_field("tx_valid", 8'(want_reply.tx_valid), 8'(o_tx_valid));
                check_field("tx_byte", want_reply.tx_byte, o_tx_byte);
                check_field("rx_dropped", 8'(want_reply.rx_dropped), 8'(o_rx_dropped));
                replies_checked++;
                if (o_rx_dropped) drops_seen++;
                if (o_tx_valid) tx_seen++;
                if (o_irq) irq_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** midi_uart_keyboard_io: FAILED **");
            $finish;
        end
    end

    initial begin
        t_row        dir_rows[$];
        t_row        row;
        t_word       w;
        int          ph;
        int          n;
        int          count;
        int          mix;
        logic [15:0] ct;

        store_head = 0;
        store_count = 0;
        data_hold = '0;
        status_q = ST_TXEMPTY;
        mode_q = '0;
        vector_q = '0;
        rows_q = '0;
        irq_q = 1'b0;
        char_time_q = CHAR_TIME_RESET;
        recv_left = 32'(CHAR_TIME_RESET);
        tx_left = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_on = 1'b1;
        rcv_idle_on = 1'b1;
        dir_rows.push_back(mk_row(CMD_READ, OFF_STATUS, 8'h00, 8'h00, '0, 1'b1, ST_TXEMPTY));
        dir_rows.push_back(mk_row(CMD_READ, OFF_DATA, 8'h00, 8'h00, '0, 1'b1, 8'h00));
        dir_rows.push_back(mk_row(CMD_READ, OFF_KEYBOARD, 8'h00, 8'h00, '1, 1'b1, 8'hFF));
        dir_rows.push_back(mk_row(CMD_READ, 3'd0, 8'h00, 8'h00, '0, 1'b1, UNMAPPED_READ));
        dir_rows.push_back(mk_row(CMD_READ, 3'd1, 8'h00, 8'h00, '0, 1'b1, UNMAPPED_READ));
        dir_rows.push_back(mk_row(CMD_READ, OFF_VECTOR, 8'h00, 8'h00, '0, 1'b1, UNMAPPED_READ));
        dir_rows.push_back(mk_row(CMD_READ, 3'd4, 8'h00, 8'h00, '0, 1'b1, UNMAPPED_READ));
        dir_rows.push_back(mk_row(CMD_READ, 3'd7, 8'h00, 8'h00, '0, 1'b1, UNMAPPED_READ));
        dir_rows.push_back(mk_row(CMD_WRITE, 3'd0, 8'hFF, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_WRITE, 3'd7, 8'hFF, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_WRITE, OFF_VECTOR, 8'hFF, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_WRITE, OFF_KEYBOARD, 8'hFF, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_READ, OFF_KEYBOARD, 8'h00, 8'h00, '1, 1'b1, 8'h88));
        dir_rows.push_back(mk_row(CMD_READ, OFF_KEYBOARD, 8'h00, 8'h00, '0, 1'b1, 8'hFF));
        dir_rows.push_back(mk_row(CMD_READ, OFF_KEYBOARD, 8'h00, 8'h00,
                                  48'h5A5A_C3C3_9696, 1'b0, 8'h00));
        // zero period acts as one
        row = '0;
        row.cfg_wr = 1'b1;
        row.cfg_val = 16'd0;
        dir_rows.push_back(row);
        dir_rows.push_back(mk_row(CMD_WRITE, OFF_STATUS, MD_TXINT | MD_RXINT, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_RX, 3'd0, 8'h00, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_RX, 3'd7, 8'h00, 8'hFF, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'h00, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_WRITE, OFF_DATA, 8'hFF, 8'h00, '0, 1'b0, 8'h00));
        // receive overrun and transmit timer on the same tick
        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'h00, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_READ, OFF_STATUS, 8'h00, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_READ, OFF_DATA, 8'h00, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_TICK, 3'd0, 8'h00, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_WRITE, OFF_STATUS, MD_RESET, 8'h00, '0, 1'b0, 8'h00));
        dir_rows.push_back(mk_row(CMD_READ, OFF_STATUS, 8'h00, 8'h00, '0, 1'b1, ST_TXEMPTY));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_wr) begin
                write_char_time(dir_rows[i].cfg_val);
            end else begin
                send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].typed_rd);
            end
        end

        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                0: ct = 16'd1;
                1: ct = 16'd3;
                2: ct = 16'd2;
                3: ct = 16'hFFFF;
                4: ct = 16'd16;
                5: ct = 16'd1;
                6: ct = 16'd7;
                7: ct = 16'd4;
                8: ct = 16'd2;
                default: ct = 16'd1;
            endcase
            mix = (ph == 4) ? MIX_FLOOD : (ph == 5) ? MIX_DRAIN : MIX_NORMAL;
            count = (mix == MIX_FLOOD) ? 285 : (mix == MIX_DRAIN) ? 80 : 33;
            sender_idle_on = (ph < 8) && (ph != 2) && (ph != 6);
            rcv_idle_on = (ph < 8) && (ph != 1);
            write_char_time(ct);
            // long receiver hold-off while words keep coming
            if (ph == 2) hold_req = 1'b1;
            for (n = 0; n < count; n++) begin
                if (ph == 3 && n == 16) wait_idle();
                w = rand_word(mix);
                send_word(w, 1'b0, 8'h00);
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("sent %0d words over %0d cycles, %0d replies checked, char_time 0 to 65535",
                 words_sent, cycle_count, replies_checked);
        $display("ring full drops %0d, bytes sent %0d, replies with irq high %0d",
                 drops_seen, tx_seen, irq_seen);
        if (fail_count == 0 && io_replies.size() == 0) begin
            $display("** midi_uart_keyboard_io: PASSED **");
        end else begin
            $display("** midi_uart_keyboard_io: FAILED **");
        end
        $finish;
    end

endmodule
